// File: src/whp_pkg.sv
// Shared definitions for the WAV header parser: field widths, RIFF/WAVE
// constants and tag lookups, and the status bundle of the remainder unit.
// No dependencies.
package whp_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned WORD_W    = 32;
	localparam int unsigned HALF_W    = 16;
	localparam int unsigned FRAME_W   = 18;
	localparam int unsigned BITS_W    = 6;
	localparam int unsigned LEFT_W    = 33;
	localparam int unsigned OFF_W     = 5;
	localparam int unsigned DIV_CNT_W = $clog2(WORD_W + 1);

	localparam logic [WORD_W-1:0] TAG_FMT  = 32'h2074_6D66;  // "fmt " little-endian
	localparam logic [WORD_W-1:0] TAG_DATA = 32'h6174_6164;  // "data" little-endian

	localparam int unsigned MIN_FILE_BYTES  = 44;
	localparam int unsigned RIFF_HDR_BYTES  = 12;
	localparam int unsigned FMT_MIN_LEN     = 16;
	localparam int unsigned CHUNK_HDR_BYTES = 8;
	localparam int unsigned FMT_BODY_LIMIT  = 16;  // body offsets past this carry nothing

	typedef struct packed {
		logic busy;
		logic done;
	} whp_div_stat_t;

	// Positions of the file header that are compared against a fixed tag.
	function automatic logic riff_checked(input logic [3:0] idx);
		logic r;
		begin
			case (idx) inside
				[4'd0:4'd3], [4'd8:4'd11]: r = 1'b1;
				default:                   r = 1'b0;
			endcase
			return r;
		end
	endfunction

	// Expected byte at a checked position: "RIFF" then "WAVE".
	function automatic logic [BYTE_W-1:0] riff_byte(input logic [3:0] idx);
		logic [BYTE_W-1:0] r;
		begin
			case (idx)
				4'd0, 4'd1: r = (idx == 4'd0) ? 8'h52 : 8'h49;  // R I
				4'd2, 4'd3: r = 8'h46;                         // F F
				4'd8:       r = 8'h57;                         // W
				4'd9:       r = 8'h41;                         // A
				4'd10:      r = 8'h56;                         // V
				4'd11:      r = 8'h45;                         // E
				default:    r = '0;
			endcase
			return r;
		end
	endfunction

endpackage

// File: src/whp_frame_mod.sv
// Bit-serial remainder unit: data length modulo frame size, one dividend
// bit per cycle, restoring form. Depends on whp_pkg.
module whp_frame_mod (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [whp_pkg::WORD_W-1:0]    dividend,
	input  logic [whp_pkg::FRAME_W-1:0]   divisor,
	output whp_pkg::whp_div_stat_t        stat,
	output logic [whp_pkg::FRAME_W-1:0]   remainder
);

	logic [whp_pkg::WORD_W-1:0]    dvd_q;
	logic [whp_pkg::FRAME_W-1:0]   dsr_q;
	logic [whp_pkg::FRAME_W-1:0]   rem_q;
	logic [whp_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;

	logic [whp_pkg::FRAME_W:0]   trial;
	logic [whp_pkg::FRAME_W+1:0] diff;
	logic [whp_pkg::FRAME_W-1:0] rem_nx;

	always_comb begin
		trial  = {rem_q, dvd_q[whp_pkg::WORD_W-1]};
		diff   = {1'b0, trial} - {2'b00, dsr_q};
		// borrow set: trial below divisor, keep it
		rem_nx = diff[whp_pkg::FRAME_W+1] ? trial[whp_pkg::FRAME_W-1:0]
		                                  : diff[whp_pkg::FRAME_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= whp_pkg::DIV_CNT_W'(whp_pkg::WORD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == whp_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[whp_pkg::WORD_W-2:0], 1'b0};
			rem_q <= rem_nx;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign remainder = rem_q;

endmodule

// File: src/wav_header_parser_unit.sv
// Top level of the WAV header parser: byte-serial RIFF/WAVE chunk walker
// with a result stage and output register. Depends on whp_pkg, whp_frame_mod.
//
// Feed a WAV file one byte per transfer on the input channel, with last_byte
// set on the final byte; one result transfer follows per file. Bytes are taken
// one per cycle while a file streams in. After the final byte the input stalls
// for a wrap-up cycle in which validity and frame size are settled and the
// parser returns to its start state, then while the bit-serial remainder unit
// trims the data length to whole frames (valid files only), then until the
// result moves into the output register. The next file's bytes are taken while
// a result still waits in the output register; only a second completed file
// waits for it. All fields of a rejected file read zero.
module wav_header_parser_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// byte stream
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [whp_pkg::BYTE_W-1:0]          data_byte,
	input  logic                                last_byte,
	// result
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                valid_res,
	output logic [whp_pkg::HALF_W-1:0]          channel_count,
	output logic [whp_pkg::WORD_W-1:0]          sample_rate,
	output logic [whp_pkg::BITS_W-1:0]          sample_bits,
	output logic [whp_pkg::FRAME_W-1:0]         frame_bytes,
	output logic [whp_pkg::WORD_W-1:0]          data_offset,
	output logic [whp_pkg::WORD_W-1:0]          data_length
);

	// parse phases
	localparam logic [1:0] PH_RIFF = 2'd0;  // file header, tags checked
	localparam logic [1:0] PH_HEAD = 2'd1;  // 8-byte chunk header
	localparam logic [1:0] PH_BODY = 2'd2;  // chunk body plus pad
	localparam logic [1:0] PH_FAIL = 2'd3;  // bad tag, bytes dropped until last

	// result stage states
	localparam logic [1:0] RS_IDLE = 2'd0;
	localparam logic [1:0] RS_DIV  = 2'd1;
	localparam logic [1:0] RS_HOLD = 2'd2;

	localparam logic [whp_pkg::LEFT_W-1:0] HDR_LEFT =
		whp_pkg::LEFT_W'(whp_pkg::CHUNK_HDR_BYTES);

	function automatic logic [whp_pkg::WORD_W-1:0] put_lane32(
		input logic [whp_pkg::WORD_W-1:0] word,
		input logic [1:0]                 lane,
		input logic [whp_pkg::BYTE_W-1:0] b
	);
		logic [whp_pkg::WORD_W-1:0] w;
		begin
			w = word;
			w[lane*whp_pkg::BYTE_W +: whp_pkg::BYTE_W] = b;
			return w;
		end
	endfunction

	function automatic logic [whp_pkg::HALF_W-1:0] put_lane16(
		input logic [whp_pkg::HALF_W-1:0] word,
		input logic                       lane,
		input logic [whp_pkg::BYTE_W-1:0] b
	);
		logic [whp_pkg::HALF_W-1:0] w;
		begin
			w = word;
			w[lane*whp_pkg::BYTE_W +: whp_pkg::BYTE_W] = b;
			return w;
		end
	endfunction

	// ---------------- parser state ----------------
	logic [whp_pkg::WORD_W-1:0] pos_q, pos_nx;       // bytes taken, saturating
	logic [1:0]                 phase_q, phase_nx;
	logic [whp_pkg::WORD_W-1:0] tag_q, tag_nx;
	logic [whp_pkg::WORD_W-1:0] len_q, len_nx;
	logic [whp_pkg::LEFT_W-1:0] left_q, left_nx;     // header or body+pad bytes left
	logic [whp_pkg::OFF_W-1:0]  off_q, off_nx;       // body offset, saturates at 16
	logic [whp_pkg::HALF_W-1:0] fmt_q, fmt_nx;
	logic [whp_pkg::HALF_W-1:0] ch_q, ch_nx;
	logic [whp_pkg::WORD_W-1:0] rate_q, rate_nx;
	logic [whp_pkg::HALF_W-1:0] bits_q, bits_nx;
	logic [whp_pkg::WORD_W-1:0] dstart_q, dstart_nx;
	logic [whp_pkg::WORD_W-1:0] dsize_q, dsize_nx;
	logic                       found_q, found_nx;
	logic                       fin_q;               // wrap-up cycle after last byte

	logic                       take;
	logic [whp_pkg::WORD_W-1:0] next_pos;
	logic [2:0]                 hidx;
	logic [whp_pkg::LEFT_W-1:0] body_total;
	logic                       is_fmt;

	assign take     = in_valid && !in_stall;
	assign next_pos = (pos_q == '1) ? pos_q : pos_q + 1'b1;
	assign hidx     = 3'(4'(whp_pkg::CHUNK_HDR_BYTES) - left_q[3:0]);
	assign is_fmt   = (tag_q == whp_pkg::TAG_FMT)
	                  && (len_q >= whp_pkg::WORD_W'(whp_pkg::FMT_MIN_LEN));

	always_comb begin
		pos_nx     = pos_q;
		phase_nx   = phase_q;
		tag_nx     = tag_q;
		len_nx     = len_q;
		left_nx    = left_q;
		off_nx     = off_q;
		fmt_nx     = fmt_q;
		ch_nx      = ch_q;
		rate_nx    = rate_q;
		bits_nx    = bits_q;
		dstart_nx  = dstart_q;
		dsize_nx   = dsize_q;
		found_nx   = found_q;
		body_total = '0;

		if (fin_q) begin
			// result captured this cycle; back to the start of a file
			pos_nx    = '0;
			phase_nx  = PH_RIFF;
			tag_nx    = '0;
			len_nx    = '0;
			left_nx   = '0;
			off_nx    = '0;
			fmt_nx    = '0;
			ch_nx     = '0;
			rate_nx   = '0;
			bits_nx   = '0;
			dstart_nx = '0;
			dsize_nx  = '0;
			found_nx  = 1'b0;
		end else if (take) begin
			pos_nx = next_pos;
			case (phase_q)
				PH_RIFF: begin
					// position stays below 12 throughout this phase
					if (whp_pkg::riff_checked(pos_q[3:0])
					    && data_byte != whp_pkg::riff_byte(pos_q[3:0])) begin
						phase_nx = PH_FAIL;
					end else if (pos_q[3:0] == 4'(whp_pkg::RIFF_HDR_BYTES - 1)) begin
						phase_nx = PH_HEAD;
						left_nx  = HDR_LEFT;
					end
				end
				PH_HEAD: begin
					if (!hidx[2])
						tag_nx = put_lane32((hidx == 3'd0) ? '0 : tag_q, hidx[1:0], data_byte);
					else
						len_nx = put_lane32((hidx == 3'd4) ? '0 : len_q, hidx[1:0], data_byte);
					left_nx = left_q - 1'b1;
					if (left_q == whp_pkg::LEFT_W'(1)) begin
						if (tag_nx == whp_pkg::TAG_DATA) begin
							dstart_nx = next_pos;
							dsize_nx  = len_nx;
							found_nx  = 1'b1;
						end
						body_total = {1'b0, len_nx} + whp_pkg::LEFT_W'(len_nx[0]);
						if (body_total == '0) begin
							left_nx = HDR_LEFT;
						end else begin
							phase_nx = PH_BODY;
							left_nx  = body_total;
							off_nx   = '0;
						end
					end
				end
				PH_BODY: begin
					if (is_fmt) begin
						case (off_q) inside
							[5'd0:5'd1]:   fmt_nx  = put_lane16(fmt_q, off_q[0], data_byte);
							[5'd2:5'd3]:   ch_nx   = put_lane16(ch_q, off_q[0], data_byte);
							[5'd4:5'd7]:   rate_nx = put_lane32(rate_q, off_q[1:0], data_byte);
							[5'd14:5'd15]: bits_nx = put_lane16(bits_q, off_q[0], data_byte);
							default:       ;
						endcase
					end
					if (off_q != whp_pkg::OFF_W'(whp_pkg::FMT_BODY_LIMIT))
						off_nx = off_q + 1'b1;
					left_nx = left_q - 1'b1;
					if (left_q == whp_pkg::LEFT_W'(1)) begin
						phase_nx = PH_HEAD;
						left_nx  = HDR_LEFT;
					end
				end
				default: ;  // failed: ignore until the last byte
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			phase_q  <= PH_RIFF;
			tag_q    <= '0;
			len_q    <= '0;
			left_q   <= '0;
			off_q    <= '0;
			fmt_q    <= '0;
			ch_q     <= '0;
			rate_q   <= '0;
			bits_q   <= '0;
			dstart_q <= '0;
			dsize_q  <= '0;
			found_q  <= 1'b0;
			fin_q    <= 1'b0;
		end else begin
			pos_q    <= pos_nx;
			phase_q  <= phase_nx;
			tag_q    <= tag_nx;
			len_q    <= len_nx;
			left_q   <= left_nx;
			off_q    <= off_nx;
			fmt_q    <= fmt_nx;
			ch_q     <= ch_nx;
			rate_q   <= rate_nx;
			bits_q   <= bits_nx;
			dstart_q <= dstart_nx;
			dsize_q  <= dsize_nx;
			found_q  <= found_nx;
			fin_q    <= take && last_byte;
		end
	end

	// ---------------- wrap-up: validity and frame size ----------------
	logic                        bits_ok;
	logic                        file_ok;
	logic [whp_pkg::FRAME_W-1:0] ch_wide;
	logic [whp_pkg::FRAME_W-1:0] frame;

	always_comb begin
		case (bits_q) inside
			16'd8, 16'd16, 16'd24, 16'd32: bits_ok = 1'b1;
			default:                       bits_ok = 1'b0;
		endcase

		// an odd body may lack only its pad byte at end of file
		file_ok = (phase_q == PH_HEAD || phase_q == PH_BODY)
		          && (pos_q >= whp_pkg::WORD_W'(whp_pkg::MIN_FILE_BYTES))
		          && !(phase_q == PH_BODY
		               && left_q > whp_pkg::LEFT_W'(len_q[0]))
		          && (fmt_q == whp_pkg::HALF_W'(1))
		          && found_q && (dsize_q != '0) && (ch_q != '0)
		          && (rate_q != '0) && bits_ok;

		// channels times bytes per sample, bytes per sample in 1..4
		ch_wide = whp_pkg::FRAME_W'(ch_q);
		case (bits_q[5:3])
			3'd1:    frame = ch_wide;
			3'd2:    frame = ch_wide << 1;
			3'd3:    frame = ch_wide + (ch_wide << 1);
			3'd4:    frame = ch_wide << 2;
			default: frame = '0;
		endcase
	end

	// ---------------- result stage ----------------
	logic [1:0]                  rs_q;
	logic                        res_ok_q;
	logic [whp_pkg::HALF_W-1:0]  res_ch_q;
	logic [whp_pkg::WORD_W-1:0]  res_rate_q;
	logic [whp_pkg::BITS_W-1:0]  res_bits_q;
	logic [whp_pkg::FRAME_W-1:0] res_frame_q;
	logic [whp_pkg::WORD_W-1:0]  res_off_q;
	logic [whp_pkg::WORD_W-1:0]  res_size_q;

	logic                        div_start;
	whp_pkg::whp_div_stat_t      div_stat;
	logic [whp_pkg::FRAME_W-1:0] div_rem;
	logic                        hand_off;

	assign div_start = fin_q && file_ok;

	whp_frame_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (dsize_q),
		.divisor   (frame),
		.stat      (div_stat),
		.remainder (div_rem)
	);

	logic                        out_valid_q;
	assign hand_off = (rs_q == RS_HOLD) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_q <= RS_IDLE;
		end else begin
			case (rs_q)
				RS_IDLE: begin
					if (fin_q)
						rs_q <= file_ok ? RS_DIV : RS_HOLD;
				end
				RS_DIV: begin
					if (div_stat.done)
						rs_q <= RS_HOLD;
				end
				RS_HOLD: begin
					if (hand_off)
						rs_q <= RS_IDLE;
				end
				default: rs_q <= RS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fin_q) begin
			res_ok_q    <= file_ok;
			res_ch_q    <= file_ok ? ch_q : '0;
			res_rate_q  <= file_ok ? rate_q : '0;
			res_bits_q  <= file_ok ? bits_q[whp_pkg::BITS_W-1:0] : '0;
			res_frame_q <= file_ok ? frame : '0;
			res_off_q   <= file_ok ? dstart_q : '0;
			res_size_q  <= file_ok ? dsize_q : '0;
		end
	end

	// ---------------- output register ----------------
	logic                        valid_res_q;
	logic [whp_pkg::HALF_W-1:0]  channel_count_q;
	logic [whp_pkg::WORD_W-1:0]  sample_rate_q;
	logic [whp_pkg::BITS_W-1:0]  sample_bits_q;
	logic [whp_pkg::FRAME_W-1:0] frame_bytes_q;
	logic [whp_pkg::WORD_W-1:0]  data_offset_q;
	logic [whp_pkg::WORD_W-1:0]  data_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (hand_off)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (hand_off) begin
			valid_res_q     <= res_ok_q;
			channel_count_q <= res_ch_q;
			sample_rate_q   <= res_rate_q;
			sample_bits_q   <= res_bits_q;
			frame_bytes_q   <= res_frame_q;
			data_offset_q   <= res_off_q;
			data_length_q   <= res_ok_q
			                   ? res_size_q - whp_pkg::WORD_W'(div_rem) : '0;
		end
	end

	// input waits during wrap-up and while a finished file sits in the result stage
	assign in_stall      = fin_q || (rs_q != RS_IDLE);

	assign out_valid     = out_valid_q;
	assign valid_res     = valid_res_q;
	assign channel_count = channel_count_q;
	assign sample_rate   = sample_rate_q;
	assign sample_bits   = sample_bits_q;
	assign frame_bytes   = frame_bytes_q;
	assign data_offset   = data_offset_q;
	assign data_length   = data_length_q;

endmodule

// File: src/whp_checker.sv
// Port-level checks for wav_header_parser_unit, bound to the top level.
// Depends on whp_pkg and wav_header_parser_unit.
module whp_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic [whp_pkg::BYTE_W-1:0]          data_byte,
	input logic                                last_byte,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic                                valid_res,
	input logic [whp_pkg::HALF_W-1:0]          channel_count,
	input logic [whp_pkg::WORD_W-1:0]          sample_rate,
	input logic [whp_pkg::BITS_W-1:0]          sample_bits,
	input logic [whp_pkg::FRAME_W-1:0]         frame_bytes,
	input logic [whp_pkg::WORD_W-1:0]          data_offset,
	input logic [whp_pkg::WORD_W-1:0]          data_length
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(valid_res)
		&& $stable(data_length) && $stable(data_offset) && $stable(frame_bytes))
		else $error("result changed while stalled");

	// a rejected file reports all zero
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> channel_count == '0 && sample_rate == '0
		&& sample_bits == '0 && frame_bytes == '0 && data_offset == '0
		&& data_length == '0)
		else $error("rejected file with nonzero fields");

	// an accepted file has a usable format
	a_accept_sane: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && valid_res |-> channel_count != '0 && sample_rate != '0
		&& frame_bytes != '0
		&& (sample_bits == 6'd8 || sample_bits == 6'd16
		    || sample_bits == 6'd24 || sample_bits == 6'd32))
		else $error("accepted file with unusable format");

	// the final byte of a file is followed by a wrap-up cycle
	a_last_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_byte |=> in_stall)
		else $error("byte taken right after final byte");

endmodule

bind wav_header_parser_unit whp_checker u_whp_checker (.*);
